### design/pgen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgen_pkg
// Shared types and constants of the permutation generator: sizes, request
// codes, register map and the packed words of both channels.
// ----------------------------------------------------------------------------
package pgen_pkg;

    localparam int MAX_POOL   = 16;
    localparam int MAX_LENGTH = 8;
    localparam int COLOR_BITS = 4;

    localparam int POOL_IDX_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int POOL_CNT_W = $clog2(MAX_POOL + 1);
    localparam int LEN_IDX_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LEN_CNT_W  = $clog2(MAX_LENGTH + 1);

    // Fixed field widths of the channels and registers.
    localparam int REQ_W         = 2;
    localparam int ENTRY_IDX_W   = 4;
    localparam int ENTRY_VAL_W   = 4;
    localparam int CODE_W        = 32;
    localparam int POOL_SIZE_W   = 5;
    localparam int CODE_LENGTH_W = 4;
    localparam int CODE_SLOTS    = CODE_W / COLOR_BITS;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_POOL_SIZE   = 1'b0;
    localparam logic REG_CODE_LENGTH = 1'b1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]       req_type;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [ENTRY_VAL_W-1:0] entry_value;
    } in_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic              exhausted;
    } out_word_t;

    typedef struct packed {
        logic [POOL_SIZE_W-1:0]   pool_size;
        logic [CODE_LENGTH_W-1:0] code_length;
    } cfg_t;

endpackage

### design/pgen_apb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgen_apb
// Configuration registers behind an APB-style port: pool size at offset 0,
// code length at offset 4. Writes complete in the access cycle.
// ----------------------------------------------------------------------------
module pgen_apb (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pgen_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pgen_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pgen_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output pgen_pkg::cfg_t                    cfg
);
    import pgen_pkg::*;

    logic [POOL_SIZE_W-1:0]   pool_size_reg;
    logic [CODE_LENGTH_W-1:0] code_length_reg;
    logic                     wr_en;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg   <= POOL_SIZE_W'(4);
            code_length_reg <= CODE_LENGTH_W'(2);
        end else if (wr_en) begin
            case (reg_sel)
                REG_POOL_SIZE:   pool_size_reg   <= pwdata[POOL_SIZE_W-1:0];
                REG_CODE_LENGTH: code_length_reg <= pwdata[CODE_LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_POOL_SIZE:   prdata = APB_DATA_W'(pool_size_reg);
            REG_CODE_LENGTH: prdata = APB_DATA_W'(code_length_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.pool_size   = pool_size_reg;
    assign cfg.code_length = code_length_reg;

endmodule

### design/pgen_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgen_engine
// Sequencer around the index store and the pool store. One next request
// walks the positions, rotates the index store one entry per cycle, swaps
// in ST_SWAP and ST_SWAP2 and reads the code back through both stores.
// ----------------------------------------------------------------------------
module pgen_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  pgen_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgen_pkg::in_word_t  in_word,
    output logic                res_valid,
    input  logic                res_ready,
    output pgen_pkg::out_word_t res_word
);
    import pgen_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_ROT_HEAD,
        ST_ROT,
        ST_ROT_TAIL,
        ST_SWAP,
        ST_SWAP2,
        ST_PACK,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic                    finished_reg;
    logic [POOL_CNT_W-1:0]   run_n_reg;
    logic [LEN_CNT_W-1:0]    run_r_reg;
    logic [POOL_CNT_W-1:0]   counts_reg [MAX_LENGTH];
    logic [MAX_POOL-1:0]     idx_valid_reg;
    logic [LEN_IDX_W-1:0]    pos_reg;
    logic [POOL_CNT_W-1:0]   j_reg;
    logic [POOL_IDX_W-1:0]   other_reg;
    logic [POOL_IDX_W-1:0]   first_reg;
    logic [LEN_CNT_W-1:0]    k_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic [LEN_IDX_W-1:0]    k1_reg;
    logic [LEN_IDX_W-1:0]    k2_reg;
    logic [CODE_W-1:0]       code_reg;
    logic                    exhausted_reg;

    // Stores and their registered read data.
    logic [POOL_IDX_W-1:0]   idx_mem  [MAX_POOL];
    logic [COLOR_BITS-1:0]   pool_mem [MAX_POOL];
    logic [POOL_IDX_W-1:0]   rd_a_reg;
    logic [POOL_IDX_W-1:0]   rd_b_reg;
    logic [COLOR_BITS-1:0]   pool_rd_reg;

    logic                    accept;
    logic                    pool_we;
    logic                    idx_we;
    logic [POOL_IDX_W-1:0]   idx_wa;
    logic [POOL_IDX_W-1:0]   idx_wd;
    logic [POOL_IDX_W-1:0]   addr_a;
    logic [POOL_IDX_W-1:0]   addr_b;
    logic [POOL_CNT_W-1:0]   pos_ext;
    logic [POOL_CNT_W-1:0]   cnt_cur;
    logic [POOL_CNT_W-1:0]   cnt_dec;
    logic [POOL_CNT_W-1:0]   other_full;
    logic [POOL_CNT_W-1:0]   n_sat;
    logic [LEN_CNT_W-1:0]    r_sat;
    logic                    pack_issue;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign res_valid = (state_reg == ST_OUT);
    assign res_word.code_word = code_reg;
    assign res_word.exhausted = exhausted_reg;

    assign n_sat = (cfg.pool_size > POOL_SIZE_W'(MAX_POOL)) ?
                   POOL_CNT_W'(MAX_POOL) : POOL_CNT_W'(cfg.pool_size);
    assign r_sat = (cfg.code_length > CODE_LENGTH_W'(MAX_LENGTH)) ?
                   LEN_CNT_W'(MAX_LENGTH) : LEN_CNT_W'(cfg.code_length);

    assign pos_ext    = POOL_CNT_W'(pos_reg);
    assign cnt_cur    = counts_reg[pos_reg];
    assign cnt_dec    = (cnt_cur == '0) ? '0 : cnt_cur - 1'b1;
    assign other_full = run_n_reg - cnt_dec;
    assign pack_issue = (k_reg < run_r_reg);

    assign pool_we = accept && (in_word.req_type == REQ_LOAD) &&
                     (POOL_CNT_W'(in_word.entry_index) < POOL_CNT_W'(MAX_POOL));

    // Index store read addresses and write port, chosen by the sequencer.
    always_comb begin
        addr_a = POOL_IDX_W'(pos_reg);
        addr_b = other_full[POOL_IDX_W-1:0];
        idx_we = 1'b0;
        idx_wa = POOL_IDX_W'(pos_reg);
        idx_wd = rd_b_reg;
        case (state_reg)
            ST_ROT_HEAD: begin
                addr_a = j_reg[POOL_IDX_W-1:0];
            end
            ST_ROT: begin
                addr_a = j_reg[POOL_IDX_W-1:0];
                idx_we = 1'b1;
                idx_wa = POOL_IDX_W'(j_reg - POOL_CNT_W'(2));
                idx_wd = rd_a_reg;
            end
            ST_ROT_TAIL: begin
                idx_we = 1'b1;
                idx_wa = POOL_IDX_W'(run_n_reg - 1'b1);
                idx_wd = first_reg;
            end
            ST_SWAP: begin
                idx_we = 1'b1;
                idx_wa = POOL_IDX_W'(pos_reg);
                idx_wd = rd_b_reg;
            end
            ST_SWAP2: begin
                idx_we = 1'b1;
                idx_wa = other_reg;
                idx_wd = first_reg;
            end
            ST_PACK: begin
                addr_a = POOL_IDX_W'(k_reg);
            end
            default: ;
        endcase
    end

    // An index entry that is not valid holds its own position.
    always_ff @(posedge aclk) begin
        if (idx_we) begin
            idx_mem[idx_wa] <= idx_wd;
        end
        rd_a_reg <= idx_valid_reg[addr_a] ? idx_mem[addr_a] : addr_a;
        rd_b_reg <= idx_valid_reg[addr_b] ? idx_mem[addr_b] : addr_b;
    end

    always_ff @(posedge aclk) begin
        if (pool_we) begin
            pool_mem[POOL_IDX_W'(in_word.entry_index)] <= COLOR_BITS'(in_word.entry_value);
        end
        pool_rd_reg <= pool_mem[rd_a_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            finished_reg  <= 1'b1;
            run_n_reg     <= '0;
            run_r_reg     <= '0;
            idx_valid_reg <= '0;
            for (int i = 0; i < MAX_LENGTH; i++) begin
                counts_reg[i] <= '0;
            end
            pos_reg       <= '0;
            j_reg         <= '0;
            other_reg     <= '0;
            first_reg     <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            k1_reg        <= '0;
            k2_reg        <= '0;
            code_reg      <= '0;
            exhausted_reg <= 1'b0;
        end else begin
            if (idx_we) begin
                idx_valid_reg[idx_wa] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (in_word.req_type)
                            REQ_START: begin
                                run_n_reg     <= n_sat;
                                run_r_reg     <= r_sat;
                                idx_valid_reg <= '0;
                                for (int i = 0; i < MAX_LENGTH; i++) begin
                                    counts_reg[i] <= (LEN_CNT_W'(i) < r_sat) ?
                                                     n_sat - POOL_CNT_W'(i) : '0;
                                end
                                code_reg <= '0;
                                if (POOL_CNT_W'(r_sat) > n_sat) begin
                                    finished_reg  <= 1'b1;
                                    exhausted_reg <= 1'b1;
                                    state_reg     <= ST_OUT;
                                end else begin
                                    finished_reg  <= 1'b0;
                                    exhausted_reg <= 1'b0;
                                    k_reg         <= '0;
                                    v1_reg        <= 1'b0;
                                    v2_reg        <= 1'b0;
                                    state_reg     <= ST_PACK;
                                end
                            end
                            REQ_NEXT: begin
                                if (finished_reg || run_r_reg == '0) begin
                                    finished_reg  <= 1'b1;
                                    exhausted_reg <= 1'b1;
                                    code_reg      <= '0;
                                    state_reg     <= ST_OUT;
                                end else begin
                                    pos_reg   <= LEN_IDX_W'(run_r_reg - 1'b1);
                                    state_reg <= ST_STEP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_STEP: begin
                    if (cnt_dec == '0) begin
                        counts_reg[pos_reg] <= run_n_reg - pos_ext;
                        j_reg               <= pos_ext + 1'b1;
                        state_reg           <= ST_ROT_HEAD;
                    end else begin
                        counts_reg[pos_reg] <= cnt_dec;
                        other_reg           <= other_full[POOL_IDX_W-1:0];
                        state_reg           <= ST_SWAP;
                    end
                end
                ST_ROT_HEAD: begin
                    first_reg <= rd_a_reg;
                    if (j_reg < run_n_reg) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_ROT;
                    end else begin
                        state_reg <= ST_ROT_TAIL;
                    end
                end
                ST_ROT: begin
                    if (j_reg < run_n_reg) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= ST_ROT_TAIL;
                    end
                end
                ST_ROT_TAIL: begin
                    // The countdown ended at every position: nothing is left.
                    if (pos_reg == '0) begin
                        finished_reg  <= 1'b1;
                        exhausted_reg <= 1'b1;
                        code_reg      <= '0;
                        state_reg     <= ST_OUT;
                    end else begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_SWAP: begin
                    first_reg <= rd_a_reg;
                    state_reg <= ST_SWAP2;
                end
                ST_SWAP2: begin
                    code_reg      <= '0;
                    exhausted_reg <= 1'b0;
                    k_reg         <= '0;
                    v1_reg        <= 1'b0;
                    v2_reg        <= 1'b0;
                    state_reg     <= ST_PACK;
                end
                ST_PACK: begin
                    // Three-deep read pipeline: index store, pool store, code slot.
                    v1_reg <= pack_issue;
                    k1_reg <= LEN_IDX_W'(k_reg);
                    v2_reg <= v1_reg;
                    k2_reg <= k1_reg;
                    if (pack_issue) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (v2_reg && (int'(k2_reg) < CODE_SLOTS)) begin
                        code_reg[int'(k2_reg) * COLOR_BITS +: COLOR_BITS] <= pool_rd_reg;
                    end
                    if (!pack_issue && !v1_reg && !v2_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### design/permutation_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_generator
// Enumerates length-r permutations of a loaded color pool in lexicographic
// order of pool position, one permutation word per next request.
// ----------------------------------------------------------------------------
// A load request writes one pool entry and gives no word. A start request
// answers with the first permutation, or with an exhausted word when r
// exceeds n. A next request walks the positions, rotates the index store
// where a countdown ends, swaps and reads the code back; an exhausted
// answer skips the read-back. The work is paced by the index store, which
// has one write port and is rotated one entry per cycle, and by the read
// chain through the index store and the pool store. The block takes no new
// request while one is in work; a finished word waits in the output
// register, so a new request is taken while it is unread.
// ----------------------------------------------------------------------------
module permutation_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pgen_pkg::in_word_t               s_word,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pgen_pkg::out_word_t              m_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pgen_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pgen_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pgen_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import pgen_pkg::*;

    cfg_t      cfg;
    logic      res_valid;
    logic      res_ready;
    out_word_t res_word;
    logic      m_valid_reg;
    out_word_t m_word_reg;

    pgen_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pgen_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // Output register: the engine hands over a word whenever the slot is
    // empty or is being emptied in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_word_reg  <= '0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_word_reg  <= res_word;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
